// File: design/uod_pkg.sv
// ----------------------------------------------------------------------------
// uod_pkg: shared constants for the unwind opcode decoder
// Operation kinds, register classes and default sizing.
// ----------------------------------------------------------------------------
package uod_pkg;

	// default limit of the operand byte count
	localparam int MAX_ULEB_BYTES_DEF = 4;

	// operation kinds
	localparam logic [3:0] K_ADD     = 4'd0;
	localparam logic [3:0] K_SUB     = 4'd1;
	localparam logic [3:0] K_REFUSE  = 4'd2;
	localparam logic [3:0] K_MASK    = 4'd3;
	localparam logic [3:0] K_FROMREG = 4'd4;
	localparam logic [3:0] K_RSVARM  = 4'd5;
	localparam logic [3:0] K_RSVIW   = 4'd6;
	localparam logic [3:0] K_RANGE   = 4'd7;
	localparam logic [3:0] K_FINISH  = 4'd8;
	localparam logic [3:0] K_SPARE   = 4'd9;
	localparam logic [3:0] K_BAD     = 4'd10;

	// register classes
	localparam logic [1:0] RC_CORE = 2'd0;
	localparam logic [1:0] RC_VFP  = 2'd1;
	localparam logic [1:0] RC_IWMX = 2'd2;

	// largest operand value whose offset still fits in 31 bits
	localparam logic [29:0] ULEB_LIMIT = 30'h1FFF_FF7E;
	localparam logic [30:0] ULEB_BASE  = 31'h204;
	localparam logic [30:0] OFS_SAT    = 31'h7FFF_FFFF;

	// one decoded operation
	typedef struct packed {
		logic [3:0]  op_kind;
		logic [1:0]  reg_class;
		logic [15:0] reg_mask;
		logic [4:0]  first_reg;
		logic [4:0]  reg_count;
		logic [30:0] vsp_offset;
		logic [2:0]  opcode_len;
		logic        uleb_overflow;
		logic        seq_end;
	} op_t;

endpackage

// File: design/uod_ifs.sv
// ----------------------------------------------------------------------------
// uod_ifs: channel interfaces of the unwind opcode decoder
// Byte input channel and decoded operation output channel.
// ----------------------------------------------------------------------------
interface uod_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] opcode_byte;
	logic       seq_last;

	modport source (output valid, opcode_byte, seq_last, input ready);
	modport sink   (input valid, opcode_byte, seq_last, output ready);
endinterface

interface uod_op_if;
	logic        valid;
	logic        ready;
	logic [3:0]  op_kind;
	logic [1:0]  reg_class;
	logic [15:0] reg_mask;
	logic [4:0]  first_reg;
	logic [4:0]  reg_count;
	logic [30:0] vsp_offset;
	logic [2:0]  opcode_len;
	logic        uleb_overflow;
	logic        seq_end;

	modport source (output valid, op_kind, reg_class, reg_mask, first_reg, reg_count,
		vsp_offset, opcode_len, uleb_overflow, seq_end, input ready);
	modport sink   (input valid, op_kind, reg_class, reg_mask, first_reg, reg_count,
		vsp_offset, opcode_len, uleb_overflow, seq_end, output ready);
endinterface

// File: design/unwind_opcode_decoder.sv
// ----------------------------------------------------------------------------
// unwind_opcode_decoder: stack unwind opcode byte stream decoder
// One opcode byte per word in, one decoded operation per completed opcode out.
// ----------------------------------------------------------------------------
//  channel | dir | modport | payload
//  bytes   | in  | sink    | opcode_byte[7:0], seq_last
//  ops     | out | source  | op_kind, reg_class, reg_mask, first_reg, reg_count,
//          |     |         | vsp_offset, opcode_len, uleb_overflow, seq_end
//
// A word is registered on entry and then decoded into the result register;
// one word per cycle is sustained while the result register is empty or taken.
// Prefix bytes and non-final operand bytes give no result and never stall, unless the sequence ends on them.
// The entry stage holds only while the result register is full and not taken.
// arst_n clears the valid flags and the decode state; no clearing pass.
// ----------------------------------------------------------------------------
module unwind_opcode_decoder
	import uod_pkg::*;
#(
	parameter int MAX_ULEB_BYTES = MAX_ULEB_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	uod_byte_if.sink   bytes,
	uod_op_if.source   ops
);

	localparam int CNT_W = $clog2(MAX_ULEB_BYTES + 1);
	localparam int ACC_W = 7 * MAX_ULEB_BYTES;
	localparam int CMP_W = (ACC_W > 30) ? ACC_W : 30;
	localparam int LEN_W = CNT_W + 1;

	// decode phase codes
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_PAIR = 2'd1;
	localparam logic [1:0] PH_ULEB = 2'd2;

	// entry stage
	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// decode state
	logic [1:0]       phase_q;
	logic [7:0]       prefix_q;
	logic [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             over_q;

	// result register
	logic out_vld_q;
	op_t  res_q;

	// next-state and result logic
	logic [ACC_W-1:0] acc_nx;
	logic [CNT_W-1:0] cnt_nx;
	logic             over_nx;
	logic [1:0]       phase_nx;
	logic             clr_uleb;
	logic             produce;
	logic             advance;
	op_t              res_d;
	logic [CMP_W-1:0] acc_ext;
	logic [LEN_W-1:0] len_raw;
	logic [2:0]       uleb_len;
	logic             is_pfx;
	logic [3:0]       hi;
	logic [3:0]       lo;

	// handshake
	assign advance     = !produce || !out_vld_q || ops.ready;
	assign bytes.ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (bytes.ready) begin
			vld_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.opcode_byte;
			last_s1 <= bytes.seq_last;
		end
	end

	// operand gathering: one 7-bit slot per operand byte
	always_comb begin
		acc_nx  = acc_q;
		cnt_nx  = cnt_q;
		over_nx = over_q;
		if (cnt_q < CNT_W'(MAX_ULEB_BYTES)) begin
			for (int j = 0; j < MAX_ULEB_BYTES; j++) begin
				if (cnt_q == CNT_W'(j)) begin
					acc_nx[7*j +: 7] = byte_s1[6:0];
				end
			end
			cnt_nx = cnt_q + 1'b1;
		end else begin
			over_nx = 1'b1;
		end
	end

	assign acc_ext  = CMP_W'(acc_nx);
	assign len_raw  = LEN_W'(cnt_nx) + 1'b1;
	assign uleb_len = (len_raw > LEN_W'(7)) ? 3'd7 : len_raw[2:0];

	assign is_pfx = (byte_s1[7:4] == 4'h8) || (byte_s1 == 8'hB1) || (byte_s1 == 8'hB3)
		|| (byte_s1 == 8'hC6) || (byte_s1 == 8'hC7) || (byte_s1 == 8'hC8)
		|| (byte_s1 == 8'hC9);

	assign hi = byte_s1[7:4];
	assign lo = byte_s1[3:0];

	// main decode
	always_comb begin
		res_d          = '0;
		res_d.seq_end  = last_s1;
		produce        = 1'b1;
		phase_nx       = PH_IDLE;
		clr_uleb       = 1'b0;
		case (phase_q)
			PH_PAIR: begin
				res_d.opcode_len = 3'd2;
				if (prefix_q[7:4] == 4'h8) begin
					if (prefix_q == 8'h80 && byte_s1 == 8'h00) begin
						res_d.op_kind = K_REFUSE;
					end else begin
						res_d.op_kind  = K_MASK;
						res_d.reg_mask = {prefix_q[3:0], byte_s1, 4'h0};
					end
				end else if (prefix_q == 8'hB1 || prefix_q == 8'hC7) begin
					if (byte_s1 != 8'h00 && hi == 4'h0) begin
						res_d.op_kind   = K_MASK;
						res_d.reg_class = (prefix_q == 8'hB1) ? RC_CORE : RC_IWMX;
						res_d.reg_mask  = {12'h000, lo};
					end else begin
						res_d.op_kind = K_SPARE;
					end
				end else if (prefix_q == 8'hB3 || prefix_q == 8'hC9) begin
					res_d.op_kind   = K_RANGE;
					res_d.reg_class = RC_VFP;
					res_d.first_reg = {1'b0, hi};
					res_d.reg_count = {1'b0, lo} + 5'd1;
				end else if (prefix_q == 8'hC6) begin
					res_d.op_kind   = K_RANGE;
					res_d.reg_class = RC_IWMX;
					res_d.first_reg = {1'b0, hi};
					res_d.reg_count = {1'b0, lo} + 5'd1;
				end else if (prefix_q == 8'hC8) begin
					res_d.op_kind   = K_RANGE;
					res_d.reg_class = RC_VFP;
					res_d.first_reg = {1'b1, hi};
					res_d.reg_count = {1'b0, lo} + 5'd1;
				end else begin
					res_d.op_kind = K_SPARE;
				end
			end
			PH_ULEB: begin
				res_d.opcode_len = uleb_len;
				if (byte_s1[7]) begin
					// continuation byte: truncated if the sequence ends here
					res_d.op_kind = K_BAD;
					produce       = last_s1;
					phase_nx      = last_s1 ? PH_IDLE : PH_ULEB;
				end else begin
					res_d.op_kind = K_ADD;
					if (over_nx || acc_ext > CMP_W'(ULEB_LIMIT)) begin
						res_d.vsp_offset    = OFS_SAT;
						res_d.uleb_overflow = 1'b1;
					end else begin
						res_d.vsp_offset = {acc_ext[28:0], 2'b00} + ULEB_BASE;
					end
				end
			end
			default: begin
				res_d.opcode_len = 3'd1;
				if (is_pfx || byte_s1 == 8'hB2) begin
					// first byte of a multi-byte opcode
					clr_uleb      = 1'b1;
					res_d.op_kind = K_BAD;
					produce       = last_s1;
					if (!last_s1) begin
						phase_nx = (byte_s1 == 8'hB2) ? PH_ULEB : PH_PAIR;
					end
				end else if (byte_s1[7:6] == 2'b00) begin
					res_d.op_kind    = K_ADD;
					res_d.vsp_offset = 31'({byte_s1[5:0], 2'b00}) + 31'd4;
				end else if (byte_s1[7:6] == 2'b01) begin
					res_d.op_kind    = K_SUB;
					res_d.vsp_offset = 31'({byte_s1[5:0], 2'b00}) + 31'd4;
				end else if (byte_s1 == 8'h9D) begin
					res_d.op_kind = K_RSVARM;
				end else if (byte_s1 == 8'h9F) begin
					res_d.op_kind = K_RSVIW;
				end else if (hi == 4'h9) begin
					res_d.op_kind   = K_FROMREG;
					res_d.first_reg = {1'b0, lo};
				end else if (hi == 4'hA) begin
					// r4 upward, plus r14 when bit 3 is set
					res_d.op_kind = K_MASK;
					for (int i = 0; i < 8; i++) begin
						res_d.reg_mask[4+i] = (3'(i) <= byte_s1[2:0]);
					end
					res_d.reg_mask[14] = res_d.reg_mask[14] | byte_s1[3];
				end else if (byte_s1 == 8'hB0) begin
					res_d.op_kind = K_FINISH;
				end else if (byte_s1[7:3] == 5'b10111 || byte_s1[7:3] == 5'b11010) begin
					res_d.op_kind   = K_RANGE;
					res_d.reg_class = RC_VFP;
					res_d.first_reg = 5'd8;
					res_d.reg_count = {2'b00, byte_s1[2:0]} + 5'd1;
				end else if (byte_s1[7:3] == 5'b11000) begin
					res_d.op_kind   = K_RANGE;
					res_d.reg_class = RC_IWMX;
					res_d.first_reg = 5'd10;
					res_d.reg_count = {2'b00, byte_s1[2:0]} + 5'd1;
				end else begin
					res_d.op_kind = K_SPARE;
				end
			end
		endcase
	end

	// decode state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			prefix_q <= '0;
			acc_q    <= '0;
			cnt_q    <= '0;
			over_q   <= 1'b0;
		end else if (vld_s1 && advance) begin
			phase_q <= phase_nx;
			if (clr_uleb) begin
				prefix_q <= byte_s1;
				acc_q    <= '0;
				cnt_q    <= '0;
				over_q   <= 1'b0;
			end else if (phase_q == PH_ULEB) begin
				acc_q  <= acc_nx;
				cnt_q  <= cnt_nx;
				over_q <= over_nx;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (vld_s1 && advance && produce) begin
			out_vld_q <= 1'b1;
		end else if (ops.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && advance && produce) begin
			res_q <= res_d;
		end
	end

	assign ops.valid         = out_vld_q;
	assign ops.op_kind       = res_q.op_kind;
	assign ops.reg_class     = res_q.reg_class;
	assign ops.reg_mask      = res_q.reg_mask;
	assign ops.first_reg     = res_q.first_reg;
	assign ops.reg_count     = res_q.reg_count;
	assign ops.vsp_offset    = res_q.vsp_offset;
	assign ops.opcode_len    = res_q.opcode_len;
	assign ops.uleb_overflow = res_q.uleb_overflow;
	assign ops.seq_end       = res_q.seq_end;

`ifndef ASSERT_OFF
	// operand byte count never passes its limit
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_ULEB_BYTES))
		else $error("operand byte count beyond limit");

	// a truncated opcode is only reported at the end of a sequence
	a_bad_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && res_q.op_kind == K_BAD |-> res_q.seq_end)
		else $error("bad result without sequence end");

	// overflow only comes with a saturated vsp add
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && res_q.uleb_overflow |->
			res_q.op_kind == K_ADD && res_q.vsp_offset == OFS_SAT)
		else $error("overflow flag on unsaturated result");

	// an empty result register never blocks the input
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_vld_q |-> bytes.ready)
		else $error("input stalled with empty result register");

	// the sequence end always leaves the decoder idle
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && advance && last_s1 |=> phase_q == PH_IDLE)
		else $error("decoder not idle after sequence end");
`endif

endmodule

// File: bench/unwind_opcode_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unwind_opcode_decoder_tb: self-checking bench for the unwind opcode decoder
// Feeds opcode bytes through the byte channel. The bench starts with a short
// table of hand-picked opcodes, then sends random opcode sequences, with
// truncated sequences and raw noise mixed in. A behavioral decoder in the
// bench predicts every operation not typed by hand, and each word on the op channel is compared
// field by field, in order. Both channels stall at random, and one long
// receiver hold-off backs the decoder up into its input.
// ----------------------------------------------------------------------------
module unwind_opcode_decoder_tb;
	import uod_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int MAXB         = MAX_ULEB_BYTES_DEF;
	localparam int HOLD_CYCLES  = 300;
	localparam int LIMIT_CYCLES = 200000;

	// opcode bytes with special meaning
	localparam logic [7:0] OPC_REFUSE_HI = 8'h80;
	localparam logic [7:0] OPC_RSV_ARM   = 8'h9D;
	localparam logic [7:0] OPC_RSV_IWMX  = 8'h9F;
	localparam logic [7:0] OPC_FINISH    = 8'hB0;
	localparam logic [7:0] OPC_POP_LO    = 8'hB1;
	localparam logic [7:0] OPC_ULEB      = 8'hB2;
	localparam logic [7:0] OPC_VFP_X     = 8'hB3;
	localparam logic [7:0] OPC_WR_RANGE  = 8'hC6;
	localparam logic [7:0] OPC_WCGR      = 8'hC7;
	localparam logic [7:0] OPC_VFP_HI    = 8'hC8;
	localparam logic [7:0] OPC_VFP_D     = 8'hC9;

	typedef enum logic [1:0] {PH_IDLE, PH_PAIR, PH_ULEB} phase_e;

	typedef struct {
		logic [7:0] b;
		bit         is_last;
		bit         typed;
		op_t        want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	uod_byte_if byte_ch ();
	uod_op_if   op_ch ();

	unwind_opcode_decoder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.ops    (op_ch)
	);

	// decoder state mirrored by the bench
	logic [7:0]  held_prefix;
	phase_e      phase;
	logic [63:0] operand;
	int          operand_bytes;
	bit          operand_long;

	op_t expected_ops[$];

	int src_idle;
	int snk_idle;
	bit hold_req;
	int hold_left;
	int cycles;
	int mismatches;
	int bytes_sent;
	int sequences_sent;
	int ops_checked;
	int bad_seen;
	int ovf_seen;

	dir_row_t dir_rows[27];

	// clock
	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	// first byte of a two-byte opcode
	function automatic bit is_pair_lead(logic [7:0] b);
		return b[7:4] == 4'h8 || b == OPC_POP_LO || b == OPC_VFP_X ||
			b == OPC_WR_RANGE || b == OPC_WCGR || b == OPC_VFP_HI || b == OPC_VFP_D;
	endfunction

	function automatic void set_range(ref op_t r, input logic [1:0] cls,
			input logic [4:0] first, input logic [4:0] cnt);
		r.op_kind   = K_RANGE;
		r.reg_class = cls;
		r.first_reg = first;
		r.reg_count = cnt;
	endfunction

	function automatic void set_mask(ref op_t r, input logic [1:0] cls, input logic [15:0] m);
		r.op_kind   = K_MASK;
		r.reg_class = cls;
		r.reg_mask  = m;
	endfunction

	// one-byte opcodes
	function automatic void decode_single(logic [7:0] b, ref op_t r);
		int sh;
		int m;
		r.opcode_len = 3'd1;
		if (b[7:6] == 2'b00) begin
			r.op_kind    = K_ADD;
			r.vsp_offset = 31'({b[5:0], 2'b00}) + 31'd4;
		end else if (b[7:6] == 2'b01) begin
			r.op_kind    = K_SUB;
			r.vsp_offset = 31'({b[5:0], 2'b00}) + 31'd4;
		end else if (b == OPC_RSV_ARM) begin
			r.op_kind = K_RSVARM;
		end else if (b == OPC_RSV_IWMX) begin
			r.op_kind = K_RSVIW;
		end else if (b[7:4] == 4'h9) begin
			r.op_kind   = K_FROMREG;
			r.first_reg = 5'(b[3:0]);
		end else if (b[7:4] == 4'hA) begin
			// r4 upward, plus r14 when bit 3 is set
			sh = b[2:0];
			m  = ((1 << (sh + 1)) - 1) << 4;
			if (b[3])
				m = m | (1 << 14);
			set_mask(r, RC_CORE, 16'(m));
		end else if (b == OPC_FINISH) begin
			r.op_kind = K_FINISH;
		end else if (b[7:3] == 5'b10111 || b[7:3] == 5'b11010) begin
			set_range(r, RC_VFP, 5'd8, 5'(b[2:0]) + 5'd1);
		end else if (b[7:3] == 5'b11000) begin
			set_range(r, RC_IWMX, 5'd10, 5'(b[2:0]) + 5'd1);
		end else begin
			r.op_kind = K_SPARE;
		end
	endfunction

	// two-byte opcodes
	function automatic void decode_pair(logic [7:0] p, logic [7:0] b, ref op_t r);
		logic [3:0] hi;
		logic [3:0] lo;
		hi = b[7:4];
		lo = b[3:0];
		r.opcode_len = 3'd2;
		if (p[7:4] == 4'h8) begin
			if (p == OPC_REFUSE_HI && b == 8'h00)
				r.op_kind = K_REFUSE;
			else
				set_mask(r, RC_CORE, {p[3:0], b, 4'b0000});
		end else if (p == OPC_POP_LO || p == OPC_WCGR) begin
			if (b != 8'h00 && hi == 4'h0)
				set_mask(r, (p == OPC_POP_LO) ? RC_CORE : RC_IWMX, 16'(lo));
			else
				r.op_kind = K_SPARE;
		end else if (p == OPC_VFP_X || p == OPC_VFP_D) begin
			set_range(r, RC_VFP, 5'(hi), 5'(lo) + 5'd1);
		end else if (p == OPC_WR_RANGE) begin
			set_range(r, RC_IWMX, 5'(hi), 5'(lo) + 5'd1);
		end else if (p == OPC_VFP_HI) begin
			set_range(r, RC_VFP, 5'd16 + 5'(hi), 5'(lo) + 5'd1);
		end else begin
			r.op_kind = K_SPARE;
		end
	endfunction

	// Advance the mirrored decoder by one byte; returns 1 when an op results.
	function automatic bit decode_byte(logic [7:0] b, bit is_last, output op_t r);
		int n;
		r = '0;
		case (phase)
			PH_PAIR: begin
				decode_pair(held_prefix, b, r);
				phase = PH_IDLE;
			end
			PH_ULEB: begin
				if (operand_bytes < MAXB) begin
					operand = operand | (64'(b[6:0]) << (7 * operand_bytes));
					operand_bytes++;
				end else begin
					operand_long = 1'b1;
				end
				n = 1 + operand_bytes;
				r.opcode_len = (n > 7) ? 3'd7 : 3'(n);
				if (b[7]) begin
					if (!is_last)
						return 1'b0;
					r.op_kind = K_BAD;
				end else begin
					r.op_kind = K_ADD;
					// offset is operand*4 + 0x204, saturating at 31 bits
					if (operand_long || operand > 64'h1FFF_FF7E) begin
						r.vsp_offset    = OFS_SAT;
						r.uleb_overflow = 1'b1;
					end else begin
						r.vsp_offset = 31'((operand << 2) + 64'h204);
					end
				end
				phase = PH_IDLE;
			end
			default: begin
				if (is_pair_lead(b) || b == OPC_ULEB) begin
					held_prefix   = b;
					phase         = (b == OPC_ULEB) ? PH_ULEB : PH_PAIR;
					operand       = '0;
					operand_bytes = 0;
					operand_long  = 1'b0;
					if (!is_last)
						return 1'b0;
					// sequence ends right after a lead byte
					r.op_kind    = K_BAD;
					r.opcode_len = 3'd1;
					phase        = PH_IDLE;
				end else begin
					decode_single(b, r);
				end
			end
		endcase
		r.seq_end = is_last;
		return 1'b1;
	endfunction

	function automatic op_t mk_op(logic [3:0] k, logic [15:0] m, logic [30:0] ofs,
			logic [2:0] len, bit ovf, bit send);
		op_t r;
		r               = '0;
		r.op_kind       = k;
		r.reg_mask      = m;
		r.vsp_offset    = ofs;
		r.opcode_len    = len;
		r.uleb_overflow = ovf;
		r.seq_end       = send;
		return r;
	endfunction

	// Offer one word; on acceptance, log its expected op (typed or predicted).
	task automatic send_byte(logic [7:0] b, bit is_last, bit typed, op_t want);
		op_t r;
		byte_ch.valid       <= 1'b1;
		byte_ch.opcode_byte <= b;
		byte_ch.seq_last    <= is_last;
		do
			@(posedge clk);
		while (byte_ch.ready !== 1'b1);
		if (decode_byte(b, is_last, r))
			expected_ops = {expected_ops, typed ? want : r};
		bytes_sent++;
		if (src_idle > 0 && $urandom_range(99) < src_idle) begin
			byte_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < src_idle);
		end
	endtask

	// append one well-formed opcode with random content
	task automatic gen_opcode(ref logic [7:0] seq[$]);
		logic [7:0] b;
		int         n;
		bit         all_ones;
		case ($urandom_range(9))
			0, 1, 2, 3: begin
				do
					b = 8'($urandom_range(255));
				while (is_pair_lead(b) || b == OPC_ULEB);
				seq = {seq, b};
			end
			4, 5, 6: begin
				case ($urandom_range(6))
					0: b = OPC_POP_LO;
					1: b = OPC_VFP_X;
					2: b = OPC_WR_RANGE;
					3: b = OPC_WCGR;
					4: b = OPC_VFP_HI;
					5: b = OPC_VFP_D;
					default: b = OPC_REFUSE_HI | 8'($urandom_range(15));
				endcase
				seq = {seq, b};
				b   = $urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
				seq = {seq, b};
			end
			default: begin
				seq      = {seq, OPC_ULEB};
				n        = ($urandom_range(3) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
				all_ones = ($urandom_range(4) == 0);
				for (int i = 0; i < n; i++) begin
					b      = all_ones ? 8'h7F : 8'($urandom_range(127));
					b[7]   = (i != n - 1);
					seq    = {seq, b};
				end
			end
		endcase
	endtask

	// one random sequence: mostly well formed, some truncated, some noise
	task automatic send_sequence();
		logic [7:0] seq[$];
		int         mode;
		int         n;
		int         op_start;
		int         keep;
		mode = $urandom_range(99);
		sequences_sent++;
		if (mode < 10) begin
			n = $urandom_range(1, 6);
			repeat (n) send_byte(8'($urandom_range(255)), $urandom_range(3) == 0, 1'b0, '0);
		end else begin
			n = $urandom_range(1, 6);
			op_start = 0;
			repeat (n) begin
				op_start = seq.size();
				gen_opcode(seq);
			end
			// cut inside the last opcode so the sequence ends mid-opcode
			if (mode < 22 && seq.size() - op_start > 1) begin
				keep = op_start + 1 + $urandom_range(seq.size() - op_start - 2);
				seq  = seq[0:keep-1];
			end
			foreach (seq[i])
				send_byte(seq[i], i == seq.size() - 1, 1'b0, '0);
		end
	endtask

	function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	// receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			op_ch.ready <= 1'b0;
		end else begin
			op_ch.ready <= ($urandom_range(99) >= snk_idle);
		end
	end

	// compare every accepted op word with the oldest expectation
	always @(posedge clk) begin
		op_t got;
		op_t want;
		if (arst_n && op_ch.valid === 1'b1 && op_ch.ready === 1'b1) begin
			got = '{op_ch.op_kind, op_ch.reg_class, op_ch.reg_mask, op_ch.first_reg,
				op_ch.reg_count, op_ch.vsp_offset, op_ch.opcode_len, op_ch.uleb_overflow,
				op_ch.seq_end};
			if (expected_ops.size() == 0) begin
				$error("unexpected op word: op_kind 0x%0h", got.op_kind);
				mismatches++;
			end else begin
				want = expected_ops.pop_front();
				cmp_field("op_kind", 32'(want.op_kind), 32'(got.op_kind));
				cmp_field("reg_class", 32'(want.reg_class), 32'(got.reg_class));
				cmp_field("reg_mask", 32'(want.reg_mask), 32'(got.reg_mask));
				cmp_field("first_reg", 32'(want.first_reg), 32'(got.first_reg));
				cmp_field("reg_count", 32'(want.reg_count), 32'(got.reg_count));
				cmp_field("vsp_offset", 32'(want.vsp_offset), 32'(got.vsp_offset));
				cmp_field("opcode_len", 32'(want.opcode_len), 32'(got.opcode_len));
				cmp_field("uleb_overflow", 32'(want.uleb_overflow), 32'(got.uleb_overflow));
				cmp_field("seq_end", 32'(want.seq_end), 32'(got.seq_end));
				ops_checked++;
				if (want.op_kind == K_BAD)
					bad_seen++;
				if (want.uleb_overflow)
					ovf_seen++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("unwind_opcode_decoder regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n              = 1'b0;
		byte_ch.valid       = 1'b0;
		byte_ch.opcode_byte = 8'h00;
		byte_ch.seq_last    = 1'b0;
		op_ch.ready         = 1'b0;
		held_prefix         = 8'h00;
		phase               = PH_IDLE;
		operand             = '0;
		operand_bytes       = 0;
		operand_long        = 1'b0;
		hold_req            = 1'b0;
		hold_left           = 0;
		cycles              = 0;
		mismatches          = 0;
		bytes_sent          = 0;
		sequences_sent      = 0;
		ops_checked         = 0;
		bad_seen            = 0;
		ovf_seen            = 0;
		src_idle            = 21;
		snk_idle            = 56;

		// directed opcodes; typed rows carry an expectation read off by hand
		dir_rows = '{
			'{8'h00, 1'b0, 1'b1, mk_op(K_ADD, 16'h0, 31'h4, 3'd1, 1'b0, 1'b0)},
			'{8'h7F, 1'b0, 1'b1, mk_op(K_SUB, 16'h0, 31'h100, 3'd1, 1'b0, 1'b0)},
			'{OPC_REFUSE_HI, 1'b0, 1'b0, '0},
			'{8'h00, 1'b0, 1'b1, mk_op(K_REFUSE, 16'h0, 31'h0, 3'd2, 1'b0, 1'b0)},
			'{8'h8F, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b0, 1'b1, mk_op(K_MASK, 16'hFFF0, 31'h0, 3'd2, 1'b0, 1'b0)},
			'{OPC_RSV_ARM, 1'b0, 1'b1, mk_op(K_RSVARM, 16'h0, 31'h0, 3'd1, 1'b0, 1'b0)},
			'{OPC_RSV_IWMX, 1'b0, 1'b1, mk_op(K_RSVIW, 16'h0, 31'h0, 3'd1, 1'b0, 1'b0)},
			'{8'hAF, 1'b0, 1'b1, mk_op(K_MASK, 16'h4FF0, 31'h0, 3'd1, 1'b0, 1'b0)},
			'{OPC_POP_LO, 1'b0, 1'b0, '0},
			'{8'h0F, 1'b0, 1'b1, mk_op(K_MASK, 16'h000F, 31'h0, 3'd2, 1'b0, 1'b0)},
			'{OPC_ULEB, 1'b0, 1'b0, '0},
			'{8'h00, 1'b0, 1'b1, mk_op(K_ADD, 16'h0, 31'h204, 3'd2, 1'b0, 1'b0)},
			'{OPC_ULEB, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b0, 1'b0, '0},
			'{8'h7F, 1'b0, 1'b1, mk_op(K_ADD, 16'h0, OFS_SAT, 3'd5, 1'b1, 1'b0)},
			'{OPC_ULEB, 1'b0, 1'b0, '0},
			'{8'h81, 1'b1, 1'b1, mk_op(K_BAD, 16'h0, 31'h0, 3'd2, 1'b0, 1'b1)},
			'{OPC_VFP_HI, 1'b1, 1'b1, mk_op(K_BAD, 16'h0, 31'h0, 3'd1, 1'b0, 1'b1)},
			'{OPC_WR_RANGE, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b0, 1'b0, '0},
			'{8'hD7, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b0, 1'b0, '0},
			'{OPC_FINISH, 1'b1, 1'b1, mk_op(K_FINISH, 16'h0, 31'h0, 3'd1, 1'b0, 1'b1)}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_byte(dir_rows[i].b, dir_rows[i].is_last, dir_rows[i].typed, dir_rows[i].want);

		// sender idles less than receiver
		while (bytes_sent < 230)
			send_sequence();

		// receiver idles less than sender
		src_idle = 56;
		snk_idle = 21;
		while (bytes_sent < 450)
			send_sequence();

		// no idling; long receiver hold-off backs up the input
		src_idle = 0;
		snk_idle = 0;
		hold_req = 1'b1;
		while (bytes_sent < 650)
			send_sequence();
		byte_ch.valid <= 1'b0;

		while (expected_ops.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d bytes in %0d sequences, %0d ops checked", bytes_sent,
			sequences_sent, ops_checked);
		$display("ops with truncation: %0d, with operand overflow: %0d", bad_seen, ovf_seen);
		if (mismatches == 0)
			$display("unwind_opcode_decoder regression: pass");
		else
			$display("unwind_opcode_decoder regression: fail");
		$finish;
	end

endmodule
